// File: rtl/core/dwps_pkg.sv
// Shared constants and types for the display window pixel streamer.
package dwps_pkg;

  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 240;
  localparam int COL_W         = 9;
  localparam int ROW_W         = 8;

  typedef logic [COL_W-1:0] col_t;
  typedef logic [ROW_W-1:0] row_t;
  typedef logic [7:0]       byte_t;
  typedef logic [3:0]       pos_t;

  localparam logic [1:0] KIND_FULL  = 2'd0;
  localparam logic [1:0] KIND_RECT  = 2'd1;
  localparam logic [1:0] KIND_PIXEL = 2'd2;

  localparam byte_t CMD_COL_SET   = 8'h2A;
  localparam byte_t CMD_PAGE_SET  = 8'h2B;
  localparam byte_t CMD_MEM_WRITE = 8'h2C;

  // Word positions of one job: colour bytes, address block, memory write.
  localparam pos_t POS_RED      = 4'd0;
  localparam pos_t POS_GREEN    = 4'd1;
  localparam pos_t POS_BLUE     = 4'd2;
  localparam pos_t POS_COL_CMD  = 4'd3;
  localparam pos_t POS_X1_HI    = 4'd4;
  localparam pos_t POS_X1_LO    = 4'd5;
  localparam pos_t POS_X2_HI    = 4'd6;
  localparam pos_t POS_X2_LO    = 4'd7;
  localparam pos_t POS_PAGE_CMD = 4'd8;
  localparam pos_t POS_Y1_HI    = 4'd9;
  localparam pos_t POS_Y1_LO    = 4'd10;
  localparam pos_t POS_Y2_HI    = 4'd11;
  localparam pos_t POS_Y2_LO    = 4'd12;
  localparam pos_t POS_MEM_CMD  = 4'd13;

  localparam col_t SCR_W     = col_t'(SCREEN_WIDTH);
  localparam row_t SCR_H     = row_t'(SCREEN_HEIGHT);
  localparam col_t SCR_W_MAX = col_t'(SCREEN_WIDTH - 1);
  localparam row_t SCR_H_MAX = row_t'(SCREEN_HEIGHT - 1);

endpackage

// File: rtl/core/dwps_if.sv
// Handshake channel interfaces for requests in and display words out.
interface dwps_req_if;
  logic                valid;
  logic                ready;
  logic [1:0]          kind;
  dwps_pkg::col_t      rect_x;
  dwps_pkg::row_t      rect_y;
  dwps_pkg::col_t      rect_width;
  dwps_pkg::row_t      rect_height;
  dwps_pkg::byte_t     red;
  dwps_pkg::byte_t     green;
  dwps_pkg::byte_t     blue;

  modport source (output valid, kind, rect_x, rect_y, rect_width, rect_height,
                  red, green, blue, input ready);
  modport sink   (input valid, kind, rect_x, rect_y, rect_width, rect_height,
                  red, green, blue, output ready);
endinterface

interface dwps_word_if;
  logic                valid;
  logic                ready;
  dwps_pkg::byte_t     out_byte;
  logic                is_data;
  logic                last;
  logic                busy_res;
  dwps_pkg::col_t      next_col;
  dwps_pkg::row_t      next_row;

  modport source (output valid, out_byte, is_data, last, busy_res, next_col,
                  next_row, input ready);
  modport sink   (input valid, out_byte, is_data, last, busy_res, next_col,
                  next_row, output ready);
endinterface

// File: rtl/core/display_window_pixel_streamer_core.sv
// Display window writer: request decode, window state and word sequencer.
// Latency: first word of a request is valid the cycle after it is accepted.
// A request emits 3 words for a pixel, 11 for an address set and 13 for the
// last pixel; the word sequencer sets this, and the next request is taken as
// the last word leaves.
// Reset (rst, synchronous): idle, full-screen window, scan at 0,0.
module display_window_pixel_streamer_core (
  input  logic         clk,
  input  logic         rst,
  dwps_req_if.sink     req,
  dwps_word_if.source  words
);

  // window and scan state
  logic            painting;
  dwps_pkg::col_t  scan_col, win_left, win_right;
  dwps_pkg::row_t  scan_row, win_top, win_bottom;
  logic            painting_next;
  dwps_pkg::col_t  scan_col_next, win_left_next, win_right_next;
  dwps_pkg::row_t  scan_row_next, win_top_next, win_bottom_next;

  // job register
  logic            active;
  dwps_pkg::pos_t  pos, pos_end;
  dwps_pkg::col_t  job_x1, job_x2, job_col;
  dwps_pkg::row_t  job_y1, job_y2, job_row;
  dwps_pkg::byte_t job_r, job_g, job_b;
  logic            job_busy;

  logic            job_load;
  dwps_pkg::pos_t  job_start_next, job_end_next;
  dwps_pkg::col_t  job_x1_next, job_x2_next;
  dwps_pkg::row_t  job_y1_next, job_y2_next;

  logic            req_fire, word_fire, at_end;

  // rectangle clamping
  dwps_pkg::col_t        rx, rw;
  dwps_pkg::row_t        ry, rh;
  logic [dwps_pkg::COL_W:0] rr_sum;
  logic [dwps_pkg::ROW_W:0] rb_sum;
  dwps_pkg::col_t        rr;
  dwps_pkg::row_t        rb;
  logic                  grow;

  // pixel advance
  logic [dwps_pkg::COL_W:0] col_inc;
  logic [dwps_pkg::ROW_W:0] row_inc;

  assign at_end    = (pos == pos_end);
  assign req.ready = !active || (words.ready && at_end);
  assign req_fire  = req.valid && req.ready;
  assign word_fire = words.valid && words.ready;

  always_comb begin
    rx = (req.rect_x > dwps_pkg::SCR_W_MAX) ? dwps_pkg::SCR_W_MAX : req.rect_x;
    ry = (req.rect_y > dwps_pkg::SCR_H_MAX) ? dwps_pkg::SCR_H_MAX : req.rect_y;
    rw = (req.rect_width == '0)  ? dwps_pkg::col_t'(1) : req.rect_width;
    rh = (req.rect_height == '0) ? dwps_pkg::row_t'(1) : req.rect_height;
    rr_sum = {1'b0, rx} + {1'b0, rw};
    rb_sum = {1'b0, ry} + {1'b0, rh};
    rr = (rr_sum > {1'b0, dwps_pkg::SCR_W}) ? dwps_pkg::SCR_W : rr_sum[dwps_pkg::COL_W-1:0];
    rb = (rb_sum > {1'b0, dwps_pkg::SCR_H}) ? dwps_pkg::SCR_H : rb_sum[dwps_pkg::ROW_W-1:0];
    grow = (rx < win_left) || (rr > win_right) || (ry < win_top) || (rb > win_bottom);
    col_inc = {1'b0, scan_col} + 1'b1;
    row_inc = {1'b0, scan_row} + 1'b1;
  end

  always_comb begin
    painting_next   = painting;
    scan_col_next   = scan_col;
    scan_row_next   = scan_row;
    win_left_next   = win_left;
    win_top_next    = win_top;
    win_right_next  = win_right;
    win_bottom_next = win_bottom;
    job_load        = 1'b0;
    job_start_next  = dwps_pkg::POS_COL_CMD;
    job_end_next    = dwps_pkg::POS_MEM_CMD;
    job_x1_next     = '0;
    job_y1_next     = '0;
    job_x2_next     = dwps_pkg::SCR_W_MAX;
    job_y2_next     = dwps_pkg::SCR_H_MAX;

    case (req.kind)
      dwps_pkg::KIND_FULL: begin
        if (!painting) begin
          painting_next   = 1'b1;
          scan_col_next   = '0;
          scan_row_next   = '0;
          win_left_next   = '0;
          win_top_next    = '0;
          win_right_next  = dwps_pkg::SCR_W;
          win_bottom_next = dwps_pkg::SCR_H;
          job_load        = 1'b1;
        end
      end
      dwps_pkg::KIND_RECT: begin
        if (painting) begin
          if (grow) begin
            win_left_next   = (rx < win_left)   ? rx : win_left;
            win_top_next    = (ry < win_top)    ? ry : win_top;
            win_right_next  = (rr > win_right)  ? rr : win_right;
            win_bottom_next = (rb > win_bottom) ? rb : win_bottom;
            scan_col_next   = win_left_next;
            scan_row_next   = win_top_next;
            job_load        = 1'b1;
          end
        end else begin
          painting_next   = 1'b1;
          win_left_next   = rx;
          win_top_next    = ry;
          win_right_next  = rr;
          win_bottom_next = rb;
          scan_col_next   = rx;
          scan_row_next   = ry;
          job_load        = 1'b1;
        end
        job_x1_next = win_left_next;
        job_y1_next = win_top_next;
        job_x2_next = win_right_next - 1'b1;
        job_y2_next = win_bottom_next - 1'b1;
      end
      dwps_pkg::KIND_PIXEL: begin
        if (painting) begin
          job_load       = 1'b1;
          job_start_next = dwps_pkg::POS_RED;
          job_end_next   = dwps_pkg::POS_BLUE;
          scan_col_next  = col_inc[dwps_pkg::COL_W-1:0];
          if (col_inc >= {1'b0, win_right}) begin
            scan_col_next = win_left;
            scan_row_next = row_inc[dwps_pkg::ROW_W-1:0];
            if (row_inc >= {1'b0, win_bottom}) begin
              // window done: back to idle, full screen re-addressed
              painting_next   = 1'b0;
              scan_col_next   = '0;
              scan_row_next   = '0;
              win_left_next   = '0;
              win_top_next    = '0;
              win_right_next  = dwps_pkg::SCR_W;
              win_bottom_next = dwps_pkg::SCR_H;
              job_end_next    = dwps_pkg::POS_Y2_LO;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      painting   <= 1'b0;
      scan_col   <= '0;
      scan_row   <= '0;
      win_left   <= '0;
      win_top    <= '0;
      win_right  <= dwps_pkg::SCR_W;
      win_bottom <= dwps_pkg::SCR_H;
    end else if (req_fire) begin
      painting   <= painting_next;
      scan_col   <= scan_col_next;
      scan_row   <= scan_row_next;
      win_left   <= win_left_next;
      win_top    <= win_top_next;
      win_right  <= win_right_next;
      win_bottom <= win_bottom_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      pos    <= '0;
    end else if (req_fire && job_load) begin
      active <= 1'b1;
      pos    <= job_start_next;
    end else if (word_fire) begin
      if (at_end) active <= 1'b0;
      else        pos    <= pos + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire && job_load) begin
      pos_end  <= job_end_next;
      job_x1   <= job_x1_next;
      job_x2   <= job_x2_next;
      job_y1   <= job_y1_next;
      job_y2   <= job_y2_next;
      job_r    <= req.red;
      job_g    <= req.green;
      job_b    <= req.blue;
      job_busy <= painting_next;
      job_col  <= scan_col_next;
      job_row  <= scan_row_next;
    end
  end

  logic [15:0] x1_w, x2_w, y1_w, y2_w;
  assign x1_w = 16'(job_x1);
  assign x2_w = 16'(job_x2);
  assign y1_w = 16'(job_y1);
  assign y2_w = 16'(job_y2);

  always_comb begin
    words.is_data = 1'b1;
    case (pos)
      dwps_pkg::POS_RED:      words.out_byte = job_r;
      dwps_pkg::POS_GREEN:    words.out_byte = job_g;
      dwps_pkg::POS_BLUE:     words.out_byte = job_b;
      dwps_pkg::POS_COL_CMD: begin
        words.out_byte = dwps_pkg::CMD_COL_SET;
        words.is_data  = 1'b0;
      end
      dwps_pkg::POS_X1_HI:    words.out_byte = x1_w[15:8];
      dwps_pkg::POS_X1_LO:    words.out_byte = x1_w[7:0];
      dwps_pkg::POS_X2_HI:    words.out_byte = x2_w[15:8];
      dwps_pkg::POS_X2_LO:    words.out_byte = x2_w[7:0];
      dwps_pkg::POS_PAGE_CMD: begin
        words.out_byte = dwps_pkg::CMD_PAGE_SET;
        words.is_data  = 1'b0;
      end
      dwps_pkg::POS_Y1_HI:    words.out_byte = y1_w[15:8];
      dwps_pkg::POS_Y1_LO:    words.out_byte = y1_w[7:0];
      dwps_pkg::POS_Y2_HI:    words.out_byte = y2_w[15:8];
      dwps_pkg::POS_Y2_LO:    words.out_byte = y2_w[7:0];
      dwps_pkg::POS_MEM_CMD: begin
        words.out_byte = dwps_pkg::CMD_MEM_WRITE;
        words.is_data  = 1'b0;
      end
      default:                words.out_byte = '0;
    endcase
  end

  assign words.valid    = active;
  assign words.last     = at_end;
  assign words.busy_res = job_busy;
  assign words.next_col = job_col;
  assign words.next_row = job_row;

endmodule

// File: rtl/core/dwps_checker.sv
// Port-level checks for the display window streamer, bound to the streamer core.
module dwps_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_ready,
  input logic           word_valid,
  input logic           word_ready,
  input logic           word_last,
  input logic           word_busy,
  input dwps_pkg::col_t word_col,
  input dwps_pkg::row_t word_row
);

  logic word_fire;
  assign word_fire = word_valid && word_ready;

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    word_valid && !word_ready |=> word_valid)
    else $error("word dropped while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !word_valid)
    else $error("word valid right after reset");

  // words of one request come back to back
  a_burst_contig: assert property (@(posedge clk) disable iff (rst)
    word_fire && !word_last |=> word_valid && $stable(word_busy)
      && $stable(word_col) && $stable(word_row))
    else $error("burst broken or status changed mid-burst");

  a_no_accept_mid_burst: assert property (@(posedge clk) disable iff (rst)
    word_valid && !word_last |-> !req_ready)
    else $error("request taken before burst finished");

endmodule

bind display_window_pixel_streamer_core dwps_checker u_dwps_checker (
  .clk        (clk),
  .rst        (rst),
  .req_ready  (req.ready),
  .word_valid (words.valid),
  .word_ready (words.ready),
  .word_last  (words.last),
  .word_busy  (words.busy_res),
  .word_col   (words.next_col),
  .word_row   (words.next_row)
);
